### design/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types, constants and the sine table series for the TRS matrix builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tmb_pkg;

  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [15:0] angle_x_deg;
    logic signed [15:0] angle_y_deg;
    logic signed [15:0] angle_z_deg;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         column_index;
    logic signed [31:0] row0_value;
    logic signed [31:0] row1_value;
    logic signed [31:0] row2_value;
    logic signed [31:0] row3_value;
    logic               last_column;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } side_t;

  localparam int SIDE_W      = $bits(side_t);
  localparam int ANGLE_BIAS  = 46080;   // 2 turns (720 degrees) in Q10.6 degrees
  localparam int ANGLE_DIV   = 5760;    // 90 degrees in Q10.6
  localparam int ANGLE_MAX_U = 78847;   // largest biased angle
  localparam int RECIP_SHIFT = 44;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  localparam logic [1:0] COL_FIRST = 2'd0;
  localparam logic [1:0] COL_LAST  = 2'd3;

  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);

  // Taylor series of sin(x), x in Q62, result rounded half up to Q(f)
  function automatic logic [63:0] sine_series(input logic [63:0] x, input int f);
    logic [127:0] pr;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    pr   = {64'd0, x} * {64'd0, x};
    x2   = pr[125:62];
    term = x;
    sum  = x;
    for (int i = 1; i <= 13; i++) begin
      pr   = {64'd0, term} * {64'd0, x2};
      term = pr[125:62] / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + (64'd1 << (61 - f))) >> (62 - f);
    return sum;
  endfunction

endpackage

`default_nettype wire

### design/tmb_ifs.sv
// ----------------------------------------------------------------------------
// tmb_ifs
// Valid/ready request channels for input items and matrix columns.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmb_in_if;
  import tmb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tmb_out_if;
  import tmb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/tmb_sine_rom.sv
// ----------------------------------------------------------------------------
// tmb_sine_rom
// Quarter-wave sine table, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_sine_rom #(
  parameter int ENTRIES = 1024,
  parameter int FBITS   = 16
) (
  input  logic                         clk,
  input  logic [$clog2(ENTRIES+1)-1:0] addr_a,
  input  logic [$clog2(ENTRIES+1)-1:0] addr_b,
  output logic [FBITS:0]               data_a,
  output logic [FBITS:0]               data_b
);
  import tmb_pkg::*;

  logic [FBITS:0] tbl [ENTRIES+1];

  for (genvar k = 0; k <= ENTRIES; k++) begin : g_tbl
    localparam logic [63:0] XK = (HALF_PI_Q62 / ENTRIES) * k
                               + ((HALF_PI_Q62 % ENTRIES) * k) / ENTRIES;
    if (k == 0) begin : g_zero
      assign tbl[k] = '0;
    end else if (k == ENTRIES) begin : g_one
      assign tbl[k] = (FBITS+1)'(1) << FBITS;
    end else begin : g_ser
      assign tbl[k] = (FBITS+1)'(sine_series(XK, FBITS));
    end
  end

  always_ff @(posedge clk) begin
    data_a <= tbl[addr_a];
    data_b <= tbl[addr_b];
  end

endmodule

`default_nettype wire

### design/tmb_front.sv
// ----------------------------------------------------------------------------
// tmb_front
// Accepts requests, converts angles, looks up sine/cosine and builds the
// rotation matrix in a free-running pipeline; admission is credit based.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_front #(
  parameter int ENTRIES = 1024,
  parameter int FBITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  tmb_in_if.sink in_chan,
  input  logic pop,
  output logic push,
  output logic [9*(FBITS+3)+tmb_pkg::SIDE_W-1:0] push_data
);
  import tmb_pkg::*;

  localparam int SW   = FBITS + 2;
  localparam int RW   = FBITS + 3;
  localparam int TMAX = ANGLE_MAX_U * ENTRIES + ANGLE_DIV / 2;
  localparam int TW   = $clog2(TMAX + 1);
  localparam int QW   = $clog2(TMAX / ANGLE_DIV + 1);
  localparam int PBW  = $clog2(4 * ENTRIES);
  localparam int IW   = $clog2(ENTRIES + 1);
  localparam logic [31:0] RECIP =
    32'(((64'd1 << RECIP_SHIFT) + ANGLE_DIV - 1) / ANGLE_DIV);

  function automatic logic signed [SW-1:0] mulf(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [2*SW-1:0] p;
    p = (2*SW)'(a) * (2*SW)'(b) + ((2*SW)'(1) <<< (FBITS - 1));
    return SW'(p >>> FBITS);
  endfunction

  logic acc;
  logic [QAW:0] occ_r, occ_nxt;
  logic [8:0] v_r;
  side_t side_r [9];

  logic signed [15:0] ang [3];
  logic [TW-1:0]  t_r    [3];
  logic [QW-1:0]  q_r    [3];
  logic [PBW-1:0] p_r    [3];
  logic [IW-1:0]  sidx_r [3];
  logic [IW-1:0]  cidx_r [3];
  logic [2:0] sneg_r, cneg_r, sneg2_r, cneg2_r;
  logic [FBITS:0] srom [3];
  logic [FBITS:0] crom [3];
  logic signed [SW-1:0] sin_r [3];
  logic signed [SW-1:0] cos_r [3];

  logic signed [SW-1:0] czsy_r, szsy_r, r00_r, r01_r, r12_r, r22_r;
  logic signed [SW-1:0] szcx_r, czcx_r, szsx_r, czsx_r, snx7_r, csx7_r, sny7_r;
  logic signed [SW-1:0] ma_r, mb_r, mc_r, md_r;
  logic signed [SW-1:0] r00b_r, r01b_r, r12b_r, r22b_r, sny8_r;
  logic signed [SW-1:0] szcx8_r, czcx8_r, szsx8_r, czsx8_r;
  logic signed [RW-1:0] rot_r [9];

  assign acc           = in_chan.valid && in_chan.ready;
  assign in_chan.ready = occ_r < (QAW+1)'(QDEPTH);

  always_comb begin
    occ_nxt = occ_r;
    if (acc && !pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!acc && pop) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      v_r   <= '0;
    end else begin
      occ_r <= occ_nxt;
      v_r   <= {v_r[7:0], acc};
    end
  end

  assign ang[0] = in_chan.payload.angle_x_deg;
  assign ang[1] = in_chan.payload.angle_y_deg;
  assign ang[2] = in_chan.payload.angle_z_deg;

  always_ff @(posedge clk) begin
    side_r[0] <= '{trans_x: in_chan.payload.trans_x, trans_y: in_chan.payload.trans_y,
                   trans_z: in_chan.payload.trans_z, scale_x: in_chan.payload.scale_x,
                   scale_y: in_chan.payload.scale_y, scale_z: in_chan.payload.scale_z};
    for (int s = 1; s < 9; s++) begin
      side_r[s] <= side_r[s-1];
    end
  end

  // angle -> binary angle -> table index
  always_ff @(posedge clk) begin
    logic signed [17:0] us;
    logic [TW+31:0]     pm;
    logic [1:0]         qd, qc;
    logic [IW-1:0]      rr;
    for (int i = 0; i < 3; i++) begin
      us     = 18'(ang[i]) + 18'(ANGLE_BIAS);
      t_r[i] <= TW'(17'(us)) * TW'(ENTRIES) + TW'(ANGLE_DIV / 2);

      pm     = (TW+32)'(t_r[i]) * (TW+32)'(RECIP);
      q_r[i] <= QW'(pm >> RECIP_SHIFT);

      if (q_r[i] >= QW'(12 * ENTRIES)) begin
        p_r[i] <= PBW'(q_r[i] - QW'(12 * ENTRIES));
      end else if (q_r[i] >= QW'(8 * ENTRIES)) begin
        p_r[i] <= PBW'(q_r[i] - QW'(8 * ENTRIES));
      end else if (q_r[i] >= QW'(4 * ENTRIES)) begin
        p_r[i] <= PBW'(q_r[i] - QW'(4 * ENTRIES));
      end else begin
        p_r[i] <= PBW'(q_r[i]);
      end

      if (p_r[i] >= PBW'(3 * ENTRIES)) begin
        qd = 2'd3;
        rr = IW'(p_r[i] - PBW'(3 * ENTRIES));
      end else if (p_r[i] >= PBW'(2 * ENTRIES)) begin
        qd = 2'd2;
        rr = IW'(p_r[i] - PBW'(2 * ENTRIES));
      end else if (p_r[i] >= PBW'(ENTRIES)) begin
        qd = 2'd1;
        rr = IW'(p_r[i] - PBW'(ENTRIES));
      end else begin
        qd = 2'd0;
        rr = IW'(p_r[i]);
      end
      qc = qd + 2'd1;
      sidx_r[i] <= qd[0] ? IW'(ENTRIES) - rr : rr;
      cidx_r[i] <= qc[0] ? IW'(ENTRIES) - rr : rr;
      sneg_r[i] <= qd[1];
      cneg_r[i] <= qc[1];
    end
    sneg2_r <= sneg_r;
    cneg2_r <= cneg_r;
  end

  for (genvar g = 0; g < 3; g++) begin : g_rom
    tmb_sine_rom #(.ENTRIES(ENTRIES), .FBITS(FBITS)) u_rom (
      .clk    (clk),
      .addr_a (sidx_r[g]),
      .addr_b (cidx_r[g]),
      .data_a (srom[g]),
      .data_b (crom[g])
    );
  end

  always_ff @(posedge clk) begin
    logic signed [SW-1:0] ms, mc;
    for (int i = 0; i < 3; i++) begin
      ms = signed'(SW'(srom[i]));
      mc = signed'(SW'(crom[i]));
      sin_r[i] <= sneg2_r[i] ? -ms : ms;
      cos_r[i] <= cneg2_r[i] ? -mc : mc;
    end
  end

  // index 0 = x, 1 = y, 2 = z
  always_ff @(posedge clk) begin
    czsy_r <= mulf(cos_r[2], sin_r[1]);
    szsy_r <= mulf(sin_r[2], sin_r[1]);
    r00_r  <= mulf(cos_r[2], cos_r[1]);
    r01_r  <= mulf(sin_r[2], cos_r[1]);
    r12_r  <= mulf(cos_r[1], sin_r[0]);
    r22_r  <= mulf(cos_r[1], cos_r[0]);
    szcx_r <= mulf(sin_r[2], cos_r[0]);
    czcx_r <= mulf(cos_r[2], cos_r[0]);
    szsx_r <= mulf(sin_r[2], sin_r[0]);
    czsx_r <= mulf(cos_r[2], sin_r[0]);
    snx7_r <= sin_r[0];
    csx7_r <= cos_r[0];
    sny7_r <= sin_r[1];

    ma_r    <= mulf(czsy_r, snx7_r);
    mb_r    <= mulf(szsy_r, snx7_r);
    mc_r    <= mulf(czsy_r, csx7_r);
    md_r    <= mulf(szsy_r, csx7_r);
    r00b_r  <= r00_r;
    r01b_r  <= r01_r;
    r12b_r  <= r12_r;
    r22b_r  <= r22_r;
    sny8_r  <= sny7_r;
    szcx8_r <= szcx_r;
    czcx8_r <= czcx_r;
    szsx8_r <= szsx_r;
    czsx8_r <= czsx_r;

    rot_r[0] <= RW'(r00b_r);
    rot_r[1] <= RW'(r01b_r);
    rot_r[2] <= -RW'(sny8_r);
    rot_r[3] <= RW'(ma_r) - RW'(szcx8_r);
    rot_r[4] <= RW'(mb_r) + RW'(czcx8_r);
    rot_r[5] <= RW'(r12b_r);
    rot_r[6] <= RW'(mc_r) + RW'(szsx8_r);
    rot_r[7] <= RW'(md_r) - RW'(czsx8_r);
    rot_r[8] <= RW'(r22b_r);
  end

  assign push = v_r[8];

  always_comb begin
    push_data = '0;
    push_data[9*RW +: SIDE_W] = side_r[8];
    for (int k = 0; k < 9; k++) begin
      push_data[k*RW +: RW] = rot_r[k];
    end
  end

endmodule

`default_nettype wire

### design/tmb_queue.sv
// ----------------------------------------------------------------------------
// tmb_queue
// Small FIFO between the matrix front end and the column back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] head
);
  import tmb_pkg::*;

  logic [DW-1:0]  mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

endmodule

`default_nettype wire

### design/tmb_back.sv
// ----------------------------------------------------------------------------
// tmb_back
// Emits one matrix column per cycle unless out_chan stalls: scale multiply (translation in column 3), round, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_back #(
  parameter int FBITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  logic [9*(FBITS+3)+tmb_pkg::SIDE_W-1:0] q_data,
  output logic pop,
  tmb_out_if.source out_chan
);
  import tmb_pkg::*;

  localparam int RW = FBITS + 3;
  localparam int PW = RW + 32;

  function automatic logic signed [31:0] sat_round(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] v;
    v = (p + (PW'(1) <<< (FBITS - 1))) >>> FBITS;
    if (v > PW'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (v < PW'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return 32'(v);
  endfunction

  side_t side;
  logic signed [RW-1:0] rot [9];
  logic signed [RW-1:0] rsel [3];
  logic signed [31:0]   ssel;
  logic signed [31:0]   trn [3];

  logic [1:0] col_r;
  logic       adv1, adv2, issue;
  logic       pv_r, ov_r;
  logic [1:0] pcol_r;
  logic signed [PW-1:0] prod_r [3];
  out_item_t  out_r;

  assign side = q_data[9*RW +: SIDE_W];
  for (genvar k = 0; k < 9; k++) begin : g_unpack
    assign rot[k] = q_data[k*RW +: RW];
  end
  assign trn[0] = side.trans_x;
  assign trn[1] = side.trans_y;
  assign trn[2] = side.trans_z;

  assign adv2  = !ov_r || out_chan.ready;
  assign adv1  = !pv_r || adv2;
  assign issue = q_valid && adv1;
  assign pop   = issue && (col_r == COL_LAST);

  always_comb begin
    case (col_r)
      2'd0:    begin ssel = side.scale_x; rsel = '{rot[0], rot[1], rot[2]}; end
      2'd1:    begin ssel = side.scale_y; rsel = '{rot[3], rot[4], rot[5]}; end
      2'd2:    begin ssel = side.scale_z; rsel = '{rot[6], rot[7], rot[8]}; end
      default: begin ssel = '0;           rsel = '{'0, '0, '0}; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= COL_FIRST;
      pv_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (issue) begin
        col_r <= col_r + 2'd1;
      end
      if (adv1) begin
        pv_r <= issue;
      end
      if (adv2) begin
        ov_r <= pv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pcol_r <= col_r;
      for (int k = 0; k < 3; k++) begin
        if (col_r == COL_LAST) begin
          prod_r[k] <= PW'(trn[k]) <<< FBITS;
        end else begin
          prod_r[k] <= PW'(rsel[k]) * PW'(ssel);
        end
      end
    end
    if (adv2 && pv_r) begin
      out_r.column_index <= pcol_r;
      out_r.row0_value   <= sat_round(prod_r[0]);
      out_r.row1_value   <= sat_round(prod_r[1]);
      out_r.row2_value   <= sat_round(prod_r[2]);
      out_r.row3_value   <= (pcol_r == COL_LAST) ? ONE_Q16 : '0;
      out_r.last_column  <= pcol_r == COL_LAST;
    end
  end

  assign out_chan.valid   = ov_r;
  assign out_chan.payload = out_r;

endmodule

`default_nettype wire

### design/trs_transform_matrix_builder_unit.sv
// Path: column 0 passes the front pipeline, the queue, the back end's product
//   and output registers; columns 1 to 3 follow on the next cycles unless
//   out_chan stalls. Throughput: one column (three scale multiplies, or the
//   translation in column 3) per cycle unless stalled; up to 8 items queue.
// Reset: synchronous, active low; clears credits, queue pointers and valids.
// ----------------------------------------------------------------------------
// trs_transform_matrix_builder_unit
// Builds the column-major model matrix T*Rz*Ry*Rx*S from one request.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_transform_matrix_builder_unit #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int FRACTION_BITS      = 16
) (
  input  logic clk,
  input  logic rst_n,
  tmb_in_if.sink    in_chan,
  tmb_out_if.source out_chan
);
  import tmb_pkg::*;

  localparam int DW = 9 * (FRACTION_BITS + 3) + SIDE_W;

  logic          push, pop, q_valid;
  logic [DW-1:0] push_data, q_data;

  tmb_front #(.ENTRIES(SINE_TABLE_ENTRIES), .FBITS(FRACTION_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .pop       (pop),
    .push      (push),
    .push_data (push_data)
  );

  tmb_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_data)
  );

  tmb_back #(.FBITS(FRACTION_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

### design/tmb_checker.sv
// ----------------------------------------------------------------------------
// tmb_checker
// Port-level checks on stall hold, column order, fixed row and request accounting.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tmb_pkg::out_item_t out_payload
);
  import tmb_pkg::*;

  logic [1:0] exp_col_r;
  logic [4:0] pend_r;
  logic       in_acc, out_acc, done;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign done    = out_acc && out_payload.last_column;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_col_r <= COL_FIRST;
      pend_r    <= '0;
    end else begin
      if (out_acc) begin
        exp_col_r <= exp_col_r + 2'd1;
      end
      pend_r <= pend_r + {4'd0, in_acc} - {4'd0, done};
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload.column_index == exp_col_r)
    else $error("column out of order");

  a_last_row3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.last_column == (out_payload.column_index == COL_LAST)) &&
                  (out_payload.row3_value == (out_payload.last_column ? ONE_Q16 : 32'sd0)))
    else $error("bad last flag or fourth row");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 5'd0)
    else $error("column without pending request");

endmodule

bind trs_transform_matrix_builder_unit tmb_checker u_tmb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_payload (out_chan.payload)
);

`default_nettype wire
